@@ rtl/core/lcs_pkg.sv @@
// Shared types and constants for the linear contrast stretch block.
package lcs_pkg;

    localparam int PixW      = 8;
    localparam int FullScale = 255;
    localparam int DivSteps  = PixW;
    localparam int CntW      = $clog2(DivSteps);

    typedef struct packed {
        logic            opcode;
        logic [PixW-1:0] pixel;
        logic            first;
    } in_item_t;

    typedef struct packed {
        logic [PixW-1:0] pixel_out;
        logic [PixW-1:0] gain;
        logic            flat;
    } out_item_t;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_APPLY   = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic measure;
        logic load_in;
        logic div_start;
        logic div_step;
        logic mul;
        logic out_load;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

@@ rtl/core/lcs_ctrl.sv @@
// Controller state machine for the linear contrast stretch block.
module lcs_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              opcode,
    input  logic              m_ready,
    input  lcs_pkg::status_t  status,
    output logic              s_ready,
    output lcs_pkg::cmd_t     cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [lcs_pkg::CntW-1:0] LastStep = lcs_pkg::CntW'(lcs_pkg::DivSteps - 1);

    logic [1:0]               state_reg, state_next;
    logic [lcs_pkg::CntW-1:0] cnt_reg, cnt_next;
    logic                     dirty_reg, dirty_next;
    logic                     accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dirty_next = dirty_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (opcode == lcs_pkg::OP_MEASURE) begin
                        cmd.measure = 1'b1;
                        dirty_next  = 1'b1;
                    end else begin
                        cmd.load_in = 1'b1;
                        if (dirty_reg) begin
                            cmd.div_start = 1'b1;
                            cnt_next      = '0;
                            state_next    = ST_DIV;
                        end else begin
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_DIV: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == LastStep) begin
                    dirty_next = 1'b0;
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!status.out_busy || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dirty_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dirty_reg <= dirty_next;
        end
    end

endmodule

@@ rtl/core/lcs_dpath.sv @@
// Datapath: min/max tracking, serial gain divider, multiply and saturate.
module lcs_dpath (
    input  logic                aclk,
    input  logic                aresetn,
    input  lcs_pkg::in_item_t   s_data,
    input  logic                m_ready,
    input  lcs_pkg::cmd_t       cmd,
    output lcs_pkg::status_t    status,
    output logic                m_valid,
    output lcs_pkg::out_item_t  m_data
);

    localparam int W  = lcs_pkg::PixW;
    localparam int PW = 2 * W;

    logic [W-1:0]  lo_reg, lo_next;
    logic [W-1:0]  hi_reg, hi_next;
    logic [W-1:0]  pix_reg;
    logic [W:0]    rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [PW-1:0] prod_reg;
    logic [W-1:0]  gain_p_reg;
    logic          flat_p_reg;
    logic          m_valid_reg, m_valid_next;
    lcs_pkg::out_item_t m_data_reg;

    logic [W-1:0]  range_w;
    logic [W:0]    rem_sh;
    logic          flat_w;
    logic [W-1:0]  gain_w;
    logic [W-1:0]  diff_w;

    // min/max tracking
    always_comb begin
        lo_next = lo_reg;
        hi_next = hi_reg;
        if (cmd.measure) begin
            if (s_data.first) begin
                lo_next = s_data.pixel;
                hi_next = s_data.pixel;
            end else begin
                if (s_data.pixel < lo_reg) lo_next = s_data.pixel;
                if (s_data.pixel > hi_reg) hi_next = s_data.pixel;
            end
        end
    end

    // restoring divide of full scale (all ones) by the range, one bit a step
    assign range_w = hi_reg - lo_reg;
    assign rem_sh  = {rem_reg[W-1:0], 1'b1};

    always_comb begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.div_start) begin
            rem_next = '0;
            quo_next = '0;
        end else if (cmd.div_step) begin
            if (rem_sh >= {1'b0, range_w}) begin
                rem_next = rem_sh - {1'b0, range_w};
                quo_next = {quo_reg[W-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[W-2:0], 1'b0};
            end
        end
    end

    // flat range: gain forced to one
    assign flat_w = !(hi_reg > lo_reg);
    assign gain_w = flat_w ? W'(1) : quo_reg;
    assign diff_w = pix_reg - lo_reg;

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load)  m_valid_next = 1'b1;
        else if (m_ready)  m_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lo_reg      <= W'(lcs_pkg::FullScale);
            hi_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            lo_reg      <= lo_next;
            hi_reg      <= hi_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.load_in) pix_reg <= s_data.pixel;
        if (cmd.mul) begin
            prod_reg   <= (pix_reg <= lo_reg) ? '0 : PW'(diff_w) * PW'(gain_w);
            gain_p_reg <= gain_w;
            flat_p_reg <= flat_w;
        end
        if (cmd.out_load) begin
            m_data_reg.pixel_out <= (prod_reg > PW'(lcs_pkg::FullScale))
                                    ? W'(lcs_pkg::FullScale) : prod_reg[W-1:0];
            m_data_reg.gain      <= gain_p_reg;
            m_data_reg.flat      <= flat_p_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;
    assign status.out_busy = m_valid_reg;

endmodule

@@ rtl/core/linear_contrast_stretch.sv @@
// Linear contrast stretch: measure pass tracks min/max, apply pass maps pixels.
// Measure request: no result; s_ready stays high, one per cycle.
// Apply request: pixel, then product, then output register (m_valid) are loaded in order; the
//   first apply after a measure or reset first runs the 8-step serial gain divider.
// One request in flight at a time; a result waiting in the output register holds the next.
// Reset (aresetn low, synchronous): idle, no result, lowest 255, highest 0.
module linear_contrast_stretch (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lcs_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lcs_pkg::out_item_t  m_data
);

    // command and status between controller and datapath
    lcs_pkg::cmd_t    cmd;
    lcs_pkg::status_t status;

    // controller: sequences measure, divide, multiply and output load
    lcs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .opcode  (s_data.opcode),
        .m_ready (m_ready),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    // datapath: min/max, gain divider, multiply, saturate, output register
    lcs_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_ready (m_ready),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_data  (m_data)
    );

endmodule
